### design/polar_rectangular_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polar/rectangular converter
// Same-cycle and next-cycle implication checks on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POLAR_RECTANGULAR_CONVERTER_UNIT_ASSERT_SVH
`define POLAR_RECTANGULAR_CONVERTER_UNIT_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define PRC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, arctangent table and item types of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prc_pkg;

  localparam int ROTATION_STEPS = 16;
  localparam int COORD_WIDTH    = 16;
  localparam int TABLE_LEN      = 24;
  localparam int STEP_W         = $clog2(TABLE_LEN);

  localparam int DATA_W   = 16;
  localparam int ANG_W    = 32;
  localparam int FIRST_W  = 17;
  localparam int SECOND_W = 16;
  localparam int HEIGHT_W = 16;

  // input LSB plus fraction bits, plus headroom for sqrt(2) * CORDIC gain
  localparam int VEC_W   = DATA_W + COORD_WIDTH + 3;
  localparam int GAIN_W  = 32;
  localparam int PROD_W  = DATA_W + GAIN_W + 1;
  localparam int RND_W   = VEC_W - COORD_WIDTH;
  localparam int MAG_W   = VEC_W - COORD_WIDTH + 7;
  localparam int MPROD_W = MAG_W + GAIN_W;
  localparam int RHO_SH  = 40;
  localparam int RHO_W   = MPROD_W - RHO_SH;

  localparam int IN_W  = ((3 * DATA_W + 7) / 8) * 8;
  localparam int OUT_W = ((FIRST_W + SECOND_W + HEIGHT_W + 7) / 8) * 8;

  // 1/K in Q32
  localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'd2608131496;
  localparam logic [ANG_W-1:0]  ANG_PI   = 32'h8000_0000;

  // round(atan(2^-i) / pi * 2^31)
  localparam logic [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic {
    KIND_CYL2RECT = 1'b0,
    KIND_RECT2CYL = 1'b1
  } kind_e;

  // vector travelling down the rotation chain
  typedef struct packed {
    kind_e                      kind;
    logic                       origin;
    logic signed [VEC_W-1:0]    x;
    logic signed [VEC_W-1:0]    y;
    logic [ANG_W-1:0]           z;
    logic [HEIGHT_W-1:0]        height;
  } vec_t;

  typedef struct packed {
    kind_e                      kind;
    logic                       origin;
    logic signed [FIRST_W-1:0]  first;
    logic signed [SECOND_W-1:0] second;
    logic [HEIGHT_W-1:0]        height;
  } res_t;

endpackage

### design/prc_front.sv
// ----------------------------------------------------------------------------
// prc_front
// Gain pre-scale multiply and quadrant fold ahead of the rotation chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  prc_pkg::kind_e                    in_kind_i,
  input  logic signed [prc_pkg::DATA_W-1:0] in_first_i,
  input  logic signed [prc_pkg::DATA_W-1:0] in_second_i,
  input  logic [prc_pkg::HEIGHT_W-1:0]      in_height_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output prc_pkg::vec_t                     out_vec_o
);
  import prc_pkg::*;

  localparam int PRE_SH = 32 - COORD_WIDTH;

  // stage A: operands and rho * (1/K)
  logic                       a_vld_q;
  kind_e                      a_kind_q;
  logic signed [DATA_W-1:0]   a_first_q, a_second_q;
  logic [HEIGHT_W-1:0]        a_height_q;
  logic signed [PROD_W-1:0]   a_prod_q, prod_d;
  logic                       a_rdy, b_rdy;

  // stage B: start vector
  logic                       b_vld_q;
  vec_t                       b_vec_q, vec_d;

  assign b_rdy      = !b_vld_q || out_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  assign prod_d = PROD_W'(in_first_i) * $signed({1'b0, GAIN_Q32});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_rdy) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_kind_q   <= in_kind_i;
      a_first_q  <= in_first_i;
      a_second_q <= in_second_i;
      a_height_q <= in_height_i;
      a_prod_q   <= prod_d;
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] scaled;
    logic signed [VEC_W-1:0]  ax, ay;
    logic [ANG_W-1:0]         zc;
    scaled = a_prod_q >>> PRE_SH;
    ax     = VEC_W'(a_first_q) <<< COORD_WIDTH;
    ay     = VEC_W'(a_second_q) <<< COORD_WIDTH;
    zc     = {a_second_q, {(ANG_W - DATA_W){1'b0}}};

    vec_d        = '0;
    vec_d.kind   = a_kind_q;
    vec_d.height = a_height_q;
    vec_d.origin = (a_kind_q == KIND_RECT2CYL) && (a_first_q == '0) && (a_second_q == '0);
    if (a_kind_q == KIND_CYL2RECT) begin
      vec_d.x = VEC_W'(scaled);
      vec_d.y = '0;
      vec_d.z = zc;
      // beyond a quarter turn: negate and step back by pi
      if (zc[ANG_W-1] ^ zc[ANG_W-2]) begin
        vec_d.x = -VEC_W'(scaled);
        vec_d.z = zc ^ ANG_PI;
      end
    end else begin
      vec_d.x = ax;
      vec_d.y = ay;
      vec_d.z = '0;
      // left half-plane: mirror through the origin, start at pi
      if (a_first_q[DATA_W-1]) begin
        vec_d.x = -ax;
        vec_d.y = -ay;
        vec_d.z = ANG_PI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_rdy) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_vld_q) begin
      b_vec_q <= vec_d;
    end
  end

  assign out_valid_o = b_vld_q;
  assign out_vec_o   = b_vec_q;

endmodule

### design/prc_cell.sv
// ----------------------------------------------------------------------------
// prc_cell
// One CORDIC micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [prc_pkg::STEP_W-1:0]  step_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  prc_pkg::vec_t               in_vec_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output prc_pkg::vec_t               out_vec_o
);
  import prc_pkg::*;

  logic vld_q;
  vec_t vec_q, vec_d;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    logic signed [VEC_W-1:0] xv, yv, xs, ys;
    logic [ANG_W-1:0]        at;
    logic                    pos;
    xv  = in_vec_i.x;
    yv  = in_vec_i.y;
    xs  = xv >>> step_i;
    ys  = yv >>> step_i;
    at  = ATAN_TAB[step_i];
    // rotation: follow the residual angle; vectoring: drive y to zero
    pos = (in_vec_i.kind == KIND_RECT2CYL) ? yv[VEC_W-1] : !in_vec_i.z[ANG_W-1];

    vec_d = in_vec_i;
    if (pos) begin
      vec_d.x = xv - ys;
      vec_d.y = yv + xs;
      vec_d.z = in_vec_i.z - at;
    end else begin
      vec_d.x = xv + ys;
      vec_d.y = yv - xs;
      vec_d.z = in_vec_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_vec_o   = vec_q;

endmodule

### design/prc_back.sv
// ----------------------------------------------------------------------------
// prc_back
// Rounding, saturation and gain removal of the magnitude; result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  prc_pkg::vec_t  in_vec_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output prc_pkg::res_t  out_res_o
);
  import prc_pkg::*;

  localparam int MAG_SH = COORD_WIDTH - 8;

  // stage C
  logic                        c_vld_q, c_rdy;
  kind_e                       c_kind_q;
  logic                        c_origin_q;
  logic signed [FIRST_W-1:0]   c_first_q, first_d;
  logic signed [SECOND_W-1:0]  c_second_q, second_d;
  logic [MPROD_W-1:0]          c_prod_q, prod_d;
  logic [HEIGHT_W-1:0]         c_height_q;

  // stage D
  logic                        d_vld_q, d_rdy;
  res_t                        d_res_q, res_d;

  assign d_rdy      = !d_vld_q || out_ready_i;
  assign c_rdy      = !c_vld_q || d_rdy;
  assign in_ready_o = c_rdy;

  always_comb begin
    logic signed [VEC_W-1:0] xv, yv, xr, yr, tf;
    logic [RND_W-1:0]        xn, yn;
    logic [MAG_W-1:0]        mag;
    logic [ANG_W-1:0]        zr;
    xv = in_vec_i.x;
    yv = in_vec_i.y;
    xr = (xv + (VEC_W'(1) <<< (COORD_WIDTH - 1))) >>> COORD_WIDTH;
    yr = (yv + (VEC_W'(1) <<< (COORD_WIDTH - 1))) >>> COORD_WIDTH;
    xn = xr[RND_W-1:0];
    yn = yr[RND_W-1:0];
    tf = xv >>> MAG_SH;
    mag = tf[VEC_W-1] ? '0 : tf[MAG_W-1:0];
    zr  = in_vec_i.z + (ANG_W'(1) << (ANG_W - SECOND_W - 1));

    prod_d = MPROD_W'(mag) * MPROD_W'(GAIN_Q32);

    // clamp when the bits above the target sign disagree with it
    if (xn[RND_W-1:FIRST_W-1] == '0 || xn[RND_W-1:FIRST_W-1] == '1) begin
      first_d = xn[FIRST_W-1:0];
    end else begin
      first_d = {xn[RND_W-1], {(FIRST_W - 1){!xn[RND_W-1]}}};
    end

    if (in_vec_i.kind == KIND_RECT2CYL) begin
      second_d = zr[ANG_W-1:ANG_W-SECOND_W];
    end else if (yn[RND_W-1:SECOND_W-1] == '0 || yn[RND_W-1:SECOND_W-1] == '1) begin
      second_d = yn[SECOND_W-1:0];
    end else begin
      second_d = {yn[RND_W-1], {(SECOND_W - 1){!yn[RND_W-1]}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (c_rdy) begin
      c_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy && in_valid_i) begin
      c_kind_q   <= in_vec_i.kind;
      c_origin_q <= in_vec_i.origin;
      c_first_q  <= first_d;
      c_second_q <= second_d;
      c_prod_q   <= prod_d;
      c_height_q <= in_vec_i.height;
    end
  end

  always_comb begin
    logic [MPROD_W-1:0] rs;
    logic [RHO_W-1:0]   rho;
    rs  = c_prod_q + (MPROD_W'(1) << (RHO_SH - 1));
    rho = rs[MPROD_W-1:RHO_SH];

    res_d        = '0;
    res_d.kind   = c_kind_q;
    res_d.origin = c_origin_q;
    res_d.height = c_height_q;
    res_d.second = c_second_q;
    if (c_kind_q == KIND_CYL2RECT) begin
      res_d.first = c_first_q;
    end else if (rho[RHO_W-1:FIRST_W-1] != '0) begin
      res_d.first = {1'b0, {(FIRST_W - 1){1'b1}}};
    end else begin
      res_d.first = FIRST_W'(rho);
    end
    if (c_origin_q) begin
      res_d.first  = '0;
      res_d.second = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (d_rdy) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && c_vld_q) begin
      d_res_q <= res_d;
    end
  end

  assign out_valid_o = d_vld_q;
  assign out_res_o   = d_res_q;

endmodule

### design/polar_rectangular_converter_unit.sv
// ----------------------------------------------------------------------------
// polar_rectangular_converter_unit
// Pipelined CORDIC converter, cylindrical <-> rectangular, z passed through.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tuser = kind; tdata = first_in, second_in, height_in
//  m_axis    out  tdata = first_out, second_out, height_out
//
//  One item per clock sustained while m_axis_tready stays high. The pipeline
//  registers are A and B in the front, one per rotation cell, C and D at the back.
//  The unrolled chain of rotation cells sets the depth; every stage has its
//  own valid bit, so bubbles close up and input keeps flowing while a
//  result waits at the output register. The input stalls only when every
//  stage holds an item. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polar_rectangular_converter_unit_assert.svh"

module polar_rectangular_converter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [15:0] first_in, [31:16] second_in, [47:32] height_in
  input  logic [prc_pkg::IN_W-1:0]     s_axis_tdata_i,
  // [0] kind
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [16:0] first_out, [32:17] second_out, [48:33] height_out, rest zero
  output logic [prc_pkg::OUT_W-1:0]    m_axis_tdata_o
);
  import prc_pkg::*;

  localparam int RES_W = FIRST_W + SECOND_W + HEIGHT_W;

  // chain links: index 0 is the front output, index ROTATION_STEPS the last cell
  vec_t chain_vec [ROTATION_STEPS+1];
  logic chain_vld [ROTATION_STEPS+1];
  logic chain_rdy [ROTATION_STEPS+1];

  res_t res;

  prc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (kind_e'(s_axis_tuser_i)),
    .in_first_i  ($signed(s_axis_tdata_i[DATA_W-1:0])),
    .in_second_i ($signed(s_axis_tdata_i[2*DATA_W-1:DATA_W])),
    .in_height_i (s_axis_tdata_i[3*DATA_W-1:2*DATA_W]),
    .out_valid_o (chain_vld[0]),
    .out_ready_i (chain_rdy[0]),
    .out_vec_o   (chain_vec[0])
  );

  // one micro-rotation per cell; step index selects shift and arctangent
  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
    prc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (STEP_W'(g)),
      .in_valid_i  (chain_vld[g]),
      .in_ready_o  (chain_rdy[g]),
      .in_vec_i    (chain_vec[g]),
      .out_valid_o (chain_vld[g+1]),
      .out_ready_i (chain_rdy[g+1]),
      .out_vec_o   (chain_vec[g+1])
    );
  end

  prc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_vld[ROTATION_STEPS]),
    .in_ready_o  (chain_rdy[ROTATION_STEPS]),
    .in_vec_i    (chain_vec[ROTATION_STEPS]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {{(OUT_W - RES_W){1'b0}}, res.height, res.second, res.first};

  // input can only block when the whole pipe is full, i.e. a result is waiting
  `PRC_ASSERT(a_stall_needs_result, !s_axis_tready_o, m_axis_tvalid_o,
              "input stalled with no result at the output")
  // a full pipe with a blocked output keeps its result steady on the output
  `PRC_ASSERT_NEXT(a_full_holds, !s_axis_tready_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o),
                   "blocked result dropped or changed")
  // magnitude is never negative
  `PRC_ASSERT(a_rho_nonneg, m_axis_tvalid_o && res.kind == KIND_RECT2CYL,
              !res.first[FIRST_W-1], "negative radius")
  // origin converts to zero radius and zero angle
  `PRC_ASSERT(a_origin_zero, m_axis_tvalid_o && res.origin,
              res.first == '0 && res.second == '0, "origin gave nonzero result")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for polar_rectangular_converter_unit. Items go through
// the input stream in both kinds. A bit-accurate CORDIC predictor queues the
// expected coordinates, and each output item is checked against them in order.
// Both sides throttle in phases, with one long output hold-off and drains
// after some of the phases.
// ----------------------------------------------------------------------------

module tb_top;
  import prc_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int HOLD_CYCLES = 400;   // long output hold-off
  localparam int TAIL_CYCLES = ROTATION_STEPS + 12;

  typedef struct {
    logic signed [FIRST_W-1:0]  first;
    logic signed [SECOND_W-1:0] second;
    logic [HEIGHT_W-1:0]        height;
  } coord_res_t;

  class coord_scoreboard;
    coord_res_t  expected_coords[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // fixed-point CORDIC, both directions, gain compensated
    function coord_res_t convert_coords(kind_e k, logic signed [15:0] a,
                                        logic signed [15:0] b, logic [15:0] h);
      longint      rx, ry, nx, ny, prod, gain;
      logic [31:0] ang, ang_rnd;
      coord_res_t  r;
      gain     = longint'({32'd0, GAIN_Q32});
      r.height = h;
      if (k == KIND_CYL2RECT) begin
        prod = longint'(a) * gain;
        rx   = prod >>> (32 - COORD_WIDTH);
        ry   = 0;
        ang  = {b, 16'h0000};
        // outside the right half: flip the vector and turn by pi
        if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
          rx  = -rx;
          ang = ang - ANG_PI;
        end
        for (int i = 0; i < ROTATION_STEPS; i++) begin
          if (!ang[31]) begin
            nx  = rx - (ry >>> i);
            ny  = ry + (rx >>> i);
            ang = ang - ATAN_TAB[i];
          end else begin
            nx  = rx + (ry >>> i);
            ny  = ry - (rx >>> i);
            ang = ang + ATAN_TAB[i];
          end
          rx = nx;
          ry = ny;
        end
        rx = (rx + (longint'(1) << (COORD_WIDTH - 1))) >>> COORD_WIDTH;
        ry = (ry + (longint'(1) << (COORD_WIDTH - 1))) >>> COORD_WIDTH;
        if (rx < -65536) rx = -65536;
        else if (rx > 65535) rx = 65535;
        if (ry < -32768) ry = -32768;
        else if (ry > 32767) ry = 32767;
        r.first  = rx[FIRST_W-1:0];
        r.second = ry[SECOND_W-1:0];
      end else if (a == 0 && b == 0) begin
        r.first  = '0;
        r.second = '0;
      end else begin
        rx  = longint'(a) <<< COORD_WIDTH;
        ry  = longint'(b) <<< COORD_WIDTH;
        ang = '0;
        // left half-plane: mirror through the origin, start at pi
        if (a < 0) begin
          rx  = -rx;
          ry  = -ry;
          ang = ANG_PI;
        end
        for (int i = 0; i < ROTATION_STEPS; i++) begin
          if (ry < 0) begin
            nx  = rx - (ry >>> i);
            ny  = ry + (rx >>> i);
            ang = ang - ATAN_TAB[i];
          end else begin
            nx  = rx + (ry >>> i);
            ny  = ry - (rx >>> i);
            ang = ang + ATAN_TAB[i];
          end
          rx = nx;
          ry = ny;
        end
        rx = rx >>> (COORD_WIDTH - 8);
        if (rx < 0) rx = 0;
        prod = (rx * gain + (longint'(1) << 39)) >>> 40;
        if (prod > 65535) prod = 65535;
        ang_rnd  = ang + 32'h0000_8000;
        r.first  = prod[FIRST_W-1:0];
        r.second = ang_rnd[31:16];
      end
      return r;
    endfunction

    function void note_item(kind_e k, logic [IN_W-1:0] d);
      expected_coords.push_back(convert_coords(k, d[15:0], d[31:16], d[47:32]));
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      coord_res_t exp_r;
      logic signed [FIRST_W-1:0]  got_first;
      logic signed [SECOND_W-1:0] got_second;
      logic [HEIGHT_W-1:0]        got_height;
      got_first  = d[16:0];
      got_second = d[32:17];
      got_height = d[48:33];
      if (expected_coords.size() == 0) begin
        $error("result with nothing expected: tdata %h", d);
        errors++;
        return;
      end
      exp_r = expected_coords.pop_front();
      if (got_first !== exp_r.first) begin
        $error("first_out: expected %0d, got %0d", exp_r.first, got_first);
        errors++;
      end
      if (got_second !== exp_r.second) begin
        $error("second_out: expected %0d, got %0d", exp_r.second, got_second);
        errors++;
      end
      if (got_height !== exp_r.height) begin
        $error("height_out: expected %0d, got %0d",
               $signed(exp_r.height), $signed(got_height));
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_coords.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic            s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  coord_scoreboard coord_check = new();

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  polar_rectangular_converter_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // handshakes are sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        coord_check.note_item(kind_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        coord_check.check_result(m_axis_tdata);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // output side: random stalls, or a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // called and returns at a falling edge; tvalid stays high on return
  task automatic send_item(input kind_e k, input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] h);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {h, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // knobs change at a rising edge so the sink process reads them cleanly
  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct,
                            input bit hold);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    if (hold) hold_req = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (coord_check.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1: return 16'($urandom_range(0, 64)) - 16'd32;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++)
      send_item(kind_e'($urandom_range(0, 1)), pick_value(), pick_value(), 16'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // polar to rectangular: zero radius, axes, quarter-turn borders, pi
    send_item(KIND_CYL2RECT, 16'h0000, 16'h0000, 16'h7FFF);
    send_item(KIND_CYL2RECT, 16'h7FFF, 16'h0000, 16'h8000);
    send_item(KIND_CYL2RECT, 16'h7FFF, 16'h4000, 16'h0001);
    send_item(KIND_CYL2RECT, 16'h7FFF, 16'hC000, 16'hFFFF);
    send_item(KIND_CYL2RECT, 16'h7FFF, 16'h4001, 16'h1234);
    send_item(KIND_CYL2RECT, 16'h7FFF, 16'hBFFF, 16'h0000);
    send_item(KIND_CYL2RECT, 16'h7FFF, 16'h8000, 16'h5555);
    send_item(KIND_CYL2RECT, 16'h7FFF, 16'h7FFF, 16'hAAAA);
    // negative radius: saturation of y at minus a quarter turn
    send_item(KIND_CYL2RECT, 16'h8000, 16'hC000, 16'h7FFF);
    send_item(KIND_CYL2RECT, 16'h8000, 16'h0000, 16'h8000);
    send_item(KIND_CYL2RECT, 16'h8000, 16'h2000, 16'h0F0F);
    // rectangular to polar: origin, angle of pi, extremes, left half-plane
    send_item(KIND_RECT2CYL, 16'h0000, 16'h0000, 16'hF0F0);
    send_item(KIND_RECT2CYL, 16'hFFFB, 16'h0000, 16'h7FFF);
    send_item(KIND_RECT2CYL, 16'h8000, 16'h0000, 16'h8000);
    send_item(KIND_RECT2CYL, 16'h7FFF, 16'h7FFF, 16'h0001);
    send_item(KIND_RECT2CYL, 16'h8000, 16'h8000, 16'hFFFE);
    send_item(KIND_RECT2CYL, 16'h8000, 16'h7FFF, 16'h3C3C);
    send_item(KIND_RECT2CYL, 16'h0000, 16'h8000, 16'hC3C3);
    send_item(KIND_RECT2CYL, 16'h0000, 16'h7FFF, 16'h0000);
    send_item(KIND_RECT2CYL, 16'hFFFF, 16'hFFFF, 16'h2222);
    send_item(KIND_RECT2CYL, 16'h0001, 16'h0000, 16'hDDDD);
    send_item(KIND_RECT2CYL, 16'hFFFF, 16'h0001, 16'h4444);
    wait_drained();

    set_idling(0, 0, 1'b0);
    random_items(200);
    set_idling(45, 0, 1'b0);
    random_items(170);
    set_idling(0, 45, 1'b0);
    random_items(170);
    set_idling(9, 9, 1'b0);
    random_items(170);

    // hold the output off while the input runs at full rate until it stalls
    set_idling(0, 0, 1'b1);
    random_items(80);
    wait_drained();

    set_idling(9, 9, 1'b0);
    random_items(110);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (coord_check.pending() != 0) begin
      $error("%0d expected results never arrived", coord_check.pending());
      coord_check.errors++;
    end
    if (coord_check.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
